@@ rtl/tte_pkg.sv @@
// shared types, codes and the length-width table of the tlv tag extractor
package tte_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_PTR_W = 2;
    localparam int OBUF_CNT_W = 3;

    localparam logic [1:0] REG_OBJECT_ID     = 2'd0;
    localparam logic [1:0] REG_TARGET_TAG    = 2'd1;
    localparam logic [1:0] REG_SIZE_ONLY     = 2'd2;
    localparam logic [1:0] REG_DEST_CAPACITY = 2'd3;

    localparam logic [1:0] PH_TAG  = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_VAL  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [2:0] ST_NOT_FOUND = 3'd0;
    localparam logic [2:0] ST_COPIED    = 3'd1;
    localparam logic [2:0] ST_TOO_SMALL = 3'd2;
    localparam logic [2:0] ST_SIZE      = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [23:0] object_id;
        logic [7:0]  target_tag;
        logic        size_only;
        logic [15:0] dest_capacity;
    } cfg_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  value_byte;
        logic [15:0] tag_length;
        logic [2:0]  status;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_t       first;
        res_t       second;
    } push_t;

    function automatic logic [1:0] length_width(input logic [23:0] obj, input logic [7:0] tag);
        logic [1:0] w;
        w = 2'd1;
        if ((obj == 24'h5FC102 && tag == 8'h3E) ||
            (obj == 24'hDFC103 && tag == 8'hBC) ||
            (obj == 24'hDFC10F && tag == 8'hBB)) begin
            w = 2'd2;
        end
        return w;
    endfunction

endpackage

@@ rtl/tlv_tag_extractor.sv @@
// top level of the tlv tag extractor
// Takes one buffer byte per word on the s_ stream and searches its tag-length-value records
// for the configured tag. An input word is accepted in every cycle while the four-word result
// queue has two free places; the word is parsed in the cycle it is accepted and its results
// (a value byte, a closing status, or both) enter the queue at the same edge. The m_ stream
// delivers one result word per cycle, so an m_ stall drops s_tready once fewer than two queue
// places are free. Write the configuration port only while idle; the block does not enforce it.
module tlv_tag_extractor
    import tte_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // data_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // value_byte, tag_length, status, zero pad
    output logic                  m_tuser,   // item_kind
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t  cfg;
    push_t push;
    res_t  out_item;
    logic  room;
    logic  in_fire;

    assign s_tready = room;
    assign in_fire  = s_tvalid & room;

    tte_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tte_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .in_fire (in_fire),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .push    (push)
    );

    tte_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {5'd0, out_item.status, out_item.tag_length, out_item.value_byte};
    assign m_tuser = out_item.item_kind;
    assign m_tlast = out_item.last;

endmodule

@@ rtl/tte_cfg.sv @@
// apb register file of the tlv tag extractor
module tte_cfg
    import tte_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_OBJECT_ID:     cfg_reg.object_id     <= pwdata[23:0];
                REG_TARGET_TAG:    cfg_reg.target_tag    <= pwdata[7:0];
                REG_SIZE_ONLY:     cfg_reg.size_only     <= pwdata[0];
                REG_DEST_CAPACITY: cfg_reg.dest_capacity <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_OBJECT_ID:     prdata = {8'd0, cfg_reg.object_id};
            REG_TARGET_TAG:    prdata = {24'd0, cfg_reg.target_tag};
            REG_SIZE_ONLY:     prdata = {31'd0, cfg_reg.size_only};
            REG_DEST_CAPACITY: prdata = {16'd0, cfg_reg.dest_capacity};
            default:           prdata = '0;
        endcase
    end

endmodule

@@ rtl/tte_core.sv @@
// tlv parse state and per-word result formation
module tte_core
    import tte_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output push_t      push
);

    logic [1:0]  phase_reg, phase_next;
    logic        match_reg, match_next;
    logic [1:0]  lbl_reg, lbl_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] vbl_reg, vbl_next;
    logic [2:0]  rc_reg, rc_next;

    logic        emit;
    logic [2:0]  fin_st;
    logic [15:0] fin_len;
    res_t        val_item;
    res_t        st_item;

    always_comb begin
        phase_next = phase_reg;
        match_next = match_reg;
        lbl_next   = lbl_reg;
        acc_next   = acc_reg;
        vbl_next   = vbl_reg;
        rc_next    = rc_reg;
        emit       = 1'b0;

        case (phase_reg)
            PH_TAG: begin
                match_next = (in_byte == cfg.target_tag);
                lbl_next   = length_width(cfg.object_id, cfg.target_tag);
                acc_next   = '0;
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                acc_next = {acc_reg[7:0], in_byte};
                lbl_next = lbl_reg - 2'd1;
                if (lbl_next == 2'd0) begin
                    if (match_reg) begin
                        if (cfg.size_only) begin
                            rc_next    = ST_SIZE;
                            phase_next = PH_DONE;
                        end else if (cfg.dest_capacity >= acc_next) begin
                            if (acc_next == 16'd0) begin
                                rc_next    = ST_COPIED;
                                phase_next = PH_DONE;
                            end else begin
                                vbl_next   = acc_next;
                                phase_next = PH_VAL;
                            end
                        end else begin
                            rc_next    = ST_TOO_SMALL;
                            phase_next = PH_DONE;
                        end
                    end else if (acc_next == 16'd0) begin
                        phase_next = PH_TAG;
                    end else begin
                        vbl_next   = acc_next;
                        phase_next = PH_VAL;
                    end
                end
            end
            PH_VAL: begin
                emit     = match_reg;
                vbl_next = vbl_reg - 16'd1;
                if (vbl_next == 16'd0) begin
                    if (match_reg) begin
                        rc_next    = ST_COPIED;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_TAG;
                    end
                end
            end
            default: ;
        endcase

        // closing status, judged on the updated state
        if (phase_next == PH_DONE) begin
            fin_st  = rc_next;
            fin_len = acc_next;
        end else if (match_next && phase_next == PH_LEN) begin
            fin_st  = ST_TRUNC;
            fin_len = '0;
        end else if (match_next && phase_next == PH_VAL) begin
            fin_st  = ST_TRUNC;
            fin_len = acc_next;
        end else begin
            fin_st  = ST_NOT_FOUND;
            fin_len = '0;
        end

        if (in_last) begin
            phase_next = PH_TAG;
            match_next = 1'b0;
            lbl_next   = '0;
            acc_next   = '0;
            vbl_next   = '0;
            rc_next    = ST_NOT_FOUND;
        end
    end

    always_comb begin
        val_item.item_kind  = KIND_VALUE;
        val_item.value_byte = in_byte;
        val_item.tag_length = acc_reg;
        val_item.status     = ST_NOT_FOUND;
        val_item.last       = 1'b0;

        st_item.item_kind  = KIND_STATUS;
        st_item.value_byte = '0;
        st_item.tag_length = fin_len;
        st_item.status     = fin_st;
        st_item.last       = 1'b1;

        push.second = st_item;
        if (emit) begin
            push.first = val_item;
        end else begin
            push.first = st_item;
        end
        if (!in_fire) begin
            push.cnt = 2'd0;
        end else begin
            push.cnt = {1'b0, emit} + {1'b0, in_last};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TAG;
            match_reg <= 1'b0;
            lbl_reg   <= '0;
            acc_reg   <= '0;
            vbl_reg   <= '0;
            rc_reg    <= ST_NOT_FOUND;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            match_reg <= match_next;
            lbl_reg   <= lbl_next;
            acc_reg   <= acc_next;
            vbl_reg   <= vbl_next;
            rc_reg    <= rc_next;
        end
    end

endmodule

@@ rtl/tte_obuf.sv @@
// small result queue taking up to two words per cycle and giving one while out_ready is high
module tte_obuf
    import tte_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  room,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_item
);

    res_t                  slot_reg [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0] wr_reg, rd_reg;
    logic [OBUF_CNT_W-1:0] cnt_reg, cnt_next;
    logic [OBUF_PTR_W-1:0] wr_plus1;
    logic                  pop;

    assign room      = (cnt_reg <= OBUF_CNT_W'(OBUF_DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = slot_reg[rd_reg];
    assign pop       = out_valid & out_ready;
    assign wr_plus1  = wr_reg + 1'b1;
    assign cnt_next  = cnt_reg + OBUF_CNT_W'(push.cnt) - OBUF_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            slot_reg[wr_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            slot_reg[wr_plus1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + OBUF_PTR_W'(push.cnt);
            rd_reg  <= rd_reg + OBUF_PTR_W'(pop);
            cnt_reg <= cnt_next;
        end
    end

endmodule
